>>> rtl/lph_pkg.sv
// shared types and codes for the linear probe hash table
`default_nettype none

package lph_pkg;

  localparam int KEY_W     = 64;
  localparam int VAL_W     = 64;
  localparam int DEF_SLOTS = 64;

  typedef enum logic [1:0] {
    FUNC_PUT    = 2'd0,
    FUNC_GET    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // result status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // slot state codes; the unused code reads as a tombstone
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic sweep_step;
    logic load;
    logic eval;
    logic commit;
  } lph_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic stop;
  } lph_sts_t;

endpackage

`default_nettype wire

>>> rtl/lph_if.sv
// valid/ready channel interfaces for operation beats and result beats
`default_nettype none

interface lph_in_if import lph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lph_out_if import lph_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic [1:0]       status;

  modport source (output valid, output found, output read_value, output status, input ready);
  modport sink   (input valid, input found, input read_value, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/lph_ctrl.sv
// sequencing state machine for sweep, probe and commit
`default_nettype none

module lph_ctrl import lph_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_func,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  output lph_cmd_t        cmd,
  input  wire lph_sts_t   sts
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CLEAR  = 6'b000100,
    ST_READ   = 6'b001000,
    ST_EVAL   = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_func == FUNC_CLEAR) ? ST_CLEAR : ST_READ;
        end
      end
      ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_COMMIT;
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.stop ? ST_COMMIT : ST_READ;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lph_dp.sv
// slot memories, probe walk registers and result registers
`default_nettype none

module lph_dp import lph_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lph_cmd_t         cmd,
  output lph_sts_t              sts,
  input  wire logic [1:0]       in_func,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [VAL_W-1:0] in_value,
  output logic                  out_found,
  output logic [VAL_W-1:0]      out_read_value,
  output logic [1:0]            out_status
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [1:0]       st_mem  [SLOTS];
  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];

  func_t            func_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [IDX_W-1:0] idx_r, cnt_r, free_idx_r, sweep_cnt_r;
  logic             free_vld_r, present_r;
  logic [1:0]       rd_st_r;
  logic [KEY_W-1:0] rd_key_r;
  logic [VAL_W-1:0] rd_val_r;
  logic             found_r;
  logic [VAL_W-1:0] rv_r;
  logic [1:0]       status_r;

  logic [IDX_W-1:0] home_idx, next_idx;
  logic             slot_empty, slot_used, slot_match, slot_free;
  logic             st_we, key_we, val_we;
  logic [IDX_W-1:0] st_wa, val_wa;
  logic [1:0]       st_wd;
  logic             found_nxt;
  logic [VAL_W-1:0] rv_nxt;
  logic [1:0]       status_nxt;

  // home slot: low three key bits reduced mod SLOTS by repeated subtract
  always_comb begin
    logic [2:0] h;
    h = in_key[2:0];
    for (int i = 0; i < 3; i++) begin
      if (32'(h) >= SLOTS) h = h - 3'(SLOTS);
    end
    home_idx = IDX_W'(h);
  end

  assign next_idx   = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign slot_empty = (rd_st_r == SLOT_EMPTY);
  assign slot_used  = (rd_st_r == SLOT_USED);
  assign slot_match = slot_used && (rd_key_r == key_r);
  assign slot_free  = !slot_used;

  assign sts = '{sweep_last: (sweep_cnt_r == LAST_IDX),
                 stop:       slot_empty || slot_match || (cnt_r == LAST_IDX)};

  // result and write-back decode
  always_comb begin
    found_nxt  = 1'b0;
    rv_nxt     = '0;
    status_nxt = STAT_DONE;
    st_we      = cmd.sweep_step;
    st_wa      = sweep_cnt_r;
    st_wd      = SLOT_EMPTY;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_wa     = idx_r;
    case (func_r)
      FUNC_PUT: begin
        found_nxt = present_r;
        if (present_r) begin
          val_we = cmd.commit;
        end else if (free_vld_r) begin
          st_we  = cmd.commit;
          st_wa  = free_idx_r;
          st_wd  = SLOT_USED;
          key_we = cmd.commit;
          val_we = cmd.commit;
          val_wa = free_idx_r;
        end else begin
          status_nxt = STAT_FULL;
        end
      end
      FUNC_GET: begin
        found_nxt = present_r;
        if (present_r) rv_nxt = rd_val_r;
        else           status_nxt = STAT_NOT_FOUND;
      end
      FUNC_REMOVE: begin
        found_nxt = present_r;
        if (present_r) begin
          st_we = cmd.commit;
          st_wa = idx_r;
          st_wd = SLOT_DELETED;
        end else begin
          status_nxt = STAT_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    rd_st_r <= st_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[free_idx_r] <= key_r;
    rd_key_r <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[val_wa] <= value_r;
    rd_val_r <= val_mem[idx_r];
  end

  // probe walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      free_vld_r  <= 1'b0;
      present_r   <= 1'b0;
    end else begin
      if (cmd.sweep_step) sweep_cnt_r <= sts.sweep_last ? '0 : sweep_cnt_r + 1'b1;
      if (cmd.load) begin
        idx_r      <= home_idx;
        cnt_r      <= '0;
        free_vld_r <= 1'b0;
        present_r  <= 1'b0;
      end else if (cmd.eval) begin
        if (slot_free && !free_vld_r) free_vld_r <= 1'b1;
        if (sts.stop) begin
          present_r <= slot_match;
        end else begin
          idx_r <= next_idx;
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func_t'(in_func);
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (cmd.eval && slot_free && !free_vld_r) free_idx_r <= idx_r;
    if (cmd.commit) begin
      found_r  <= found_nxt;
      rv_r     <= rv_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_found      = found_r;
  assign out_read_value = rv_r;
  assign out_status     = status_r;

endmodule

`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// top level of the open-addressing key/value table with linear probing
// a put, get or remove probes k slots (1 <= k <= SLOTS); a clear sweeps every slot
// throughput: one operation at a time; the next beat is taken the cycle after commit;
//   each probed slot takes a READ state (registered slot memory read), then an EVAL state
// reset: synchronous active low; after reset an init sweep empties every slot
//   and in_chan.ready stays low until it ends
`default_nettype none

module linear_probe_hash_table import lph_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lph_in_if.sink      in_chan,
  lph_out_if.source   out_chan
);

  // command and status between the sequencer and the datapath
  lph_cmd_t cmd;
  lph_sts_t sts;

  // sequencer: init sweep, accept, clear sweep or probe read/eval loop, commit into the result register
  lph_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_func   (in_chan.func),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: slot state/key/value memories, probe index, free-slot tracking, result beat
  lph_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_chan.func),
    .in_key         (in_chan.key),
    .in_value       (in_chan.value),
    .out_found      (out_chan.found),
    .out_read_value (out_chan.read_value),
    .out_status     (out_chan.status)
  );

endmodule

`default_nettype wire

>>> dv/linear_probe_hash_table_checker.sv
// checker that predicts the table's replies and compares them with the result beats
`timescale 1ns / 100ps

module linear_probe_hash_table_checker import lph_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic [KEY_W-1:0] in_key,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             out_found,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic [1:0]       out_status,
  output int               fail_count,
  output int               pending,
  output int               full_count,
  output int               hit_count
);

  typedef struct {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic [1:0]       status;
  } table_reply_t;

  // shadow copy of the table
  logic [1:0]       slot_state [SLOTS];
  logic [KEY_W-1:0] slot_key   [SLOTS];
  logic [VAL_W-1:0] slot_val   [SLOTS];

  table_reply_t pending_replies [$];
  int fails = 0;
  int fulls = 0;
  int hits  = 0;

  function automatic void empty_table();
    for (int i = 0; i < SLOTS; i++) slot_state[i] = SLOT_EMPTY;
  endfunction

  // walk the probe path, then apply the operation to the shadow table
  function automatic table_reply_t predict_table_op(func_t op, logic [KEY_W-1:0] k,
                                                    logic [VAL_W-1:0] v);
    table_reply_t r;
    int idx;
    int hit_at;
    int free_at;
    bit present;
    bit stop;
    r.found      = 1'b0;
    r.read_value = '0;
    r.status     = STAT_DONE;
    if (op == FUNC_CLEAR) begin
      empty_table();
      return r;
    end
    idx     = int'(k[2:0]) % SLOTS;
    free_at = SLOTS;
    hit_at  = 0;
    present = 1'b0;
    stop    = 1'b0;
    for (int n = 0; n < SLOTS && !stop; n++) begin
      if (slot_state[idx] == SLOT_EMPTY) begin
        if (free_at == SLOTS) free_at = idx;
        stop = 1'b1;
      end else if (slot_state[idx] == SLOT_USED) begin
        if (slot_key[idx] == k) begin
          hit_at  = idx;
          present = 1'b1;
          stop    = 1'b1;
        end
      end else if (free_at == SLOTS) begin
        // tombstone, or the unused code that reads as one
        free_at = idx;
      end
      if (!stop) idx = (idx + 1 == SLOTS) ? 0 : idx + 1;
    end
    r.found = present;
    case (op)
      FUNC_PUT: begin
        if (present) begin
          slot_val[hit_at] = v;
        end else if (free_at < SLOTS) begin
          slot_state[free_at] = SLOT_USED;
          slot_key[free_at]   = k;
          slot_val[free_at]   = v;
        end else begin
          r.status = STAT_FULL;
        end
      end
      FUNC_GET: begin
        if (present) r.read_value = slot_val[hit_at];
        else r.status = STAT_NOT_FOUND;
      end
      default: begin
        if (present) slot_state[hit_at] = SLOT_DELETED;
        else r.status = STAT_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t want;
    if (!rst_n) begin
      empty_table();
      pending_replies.delete();
    end else begin
      if (in_valid && in_ready)
        pending_replies.push_back(predict_table_op(func_t'(in_func), in_key, in_value));
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("result beat with nothing expected: found %0b value %h status %0d",
                                 out_found, out_read_value, out_status));
        end else begin
          want = pending_replies.pop_front();
          if (out_found !== want.found || out_read_value !== want.read_value ||
              out_status !== want.status)
            note_failure($sformatf("exp found %0b value %h status %0d, got %0b %h %0d",
                                   want.found, want.read_value, want.status,
                                   out_found, out_read_value, out_status));
          if (want.status == STAT_FULL) fulls++;
          if (want.found) hits++;
        end
      end
    end
    fail_count <= fails;
    pending    <= pending_replies.size();
    full_count <= fulls;
    hit_count  <= hits;
  end

endmodule

>>> dv/linear_probe_hash_table_tb.sv
// testbench top: stimulus, idling, and verdict for the linear probe hash table
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lph_pkg::*;

  localparam int SLOTS       = DEF_SLOTS;
  localparam int ITEM_TARGET = 1300;
  // no idling on either side for the tail of the run
  localparam int CALM_ITEMS  = 150;
  localparam int POOL_N      = 24;
  localparam logic [63:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;
  int   idle_pct = 0;
  int   items_sent = 0;
  int   op_count [4];
  int   fail_count, pending, full_count, hit_count;

  logic [KEY_W-1:0] key_pool  [POOL_N];
  logic [KEY_W-1:0] fill_keys [SLOTS];

  lph_in_if  in_chan ();
  lph_out_if out_chan ();

  linear_probe_hash_table #(.SLOTS(SLOTS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  linear_probe_hash_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_chan.valid),
    .in_ready       (in_chan.ready),
    .in_func        (in_chan.func),
    .in_key         (in_chan.key),
    .in_value       (in_chan.value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_found      (out_chan.found),
    .out_read_value (out_chan.read_value),
    .out_status     (out_chan.status),
    .fail_count     (fail_count),
    .pending        (pending),
    .full_count     (full_count),
    .hit_count      (hit_count)
  );

  always #2 clk = ~clk;

  // hard stop; the slowest legal run is several times shorter
  initial begin
    #(3_000_000);
    $display("linear_probe_hash_table_tb: errors");
    $finish;
  end

  // result side: ready drops in bursts at random, never once calm
  initial begin : result_sink
    int stall;
    stall = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        stall--;
      end else if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_chan.ready <= 1'b0;
        stall = $urandom_range(0, 2);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly pool keys so that hits happen, some near misses that differ in a
  // single bit (the whole key must be compared), some fresh keys
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, POOL_N - 1)];
    if (r < 82) return key_pool[$urandom_range(0, POOL_N - 1)] ^ (64'd1 << $urandom_range(0, 63));
    return rand_word();
  endfunction

  // one operation beat; an optional gap with valid low goes before it
  task automatic send_op(input func_t op, input logic [63:0] k, input logic [63:0] v);
    if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.func  <= op;
    in_chan.key   <= k;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    op_count[op]++;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
  endtask

  // fill the table to the brim, then probe it whole: full puts, misses that
  // walk every slot, tombstone reuse once entries are removed
  task automatic fill_episode();
    send_op(FUNC_CLEAR, rand_word(), rand_word());
    for (int i = 0; i < SLOTS; i++) begin
      fill_keys[i] = rand_word();
      send_op(FUNC_PUT, fill_keys[i], rand_word());
    end
    send_op(FUNC_PUT, rand_word(), rand_word());
    send_op(FUNC_GET, rand_word(), rand_word());
    send_op(FUNC_PUT, fill_keys[$urandom_range(0, SLOTS - 1)], rand_word());
    repeat (3) send_op(FUNC_REMOVE, fill_keys[$urandom_range(0, SLOTS - 1)], rand_word());
    // no empty slot left, so a miss walks past the tombstones all the way round
    send_op(FUNC_GET, rand_word(), rand_word());
    send_op(FUNC_PUT, rand_word(), rand_word());
    repeat (4) send_op(FUNC_GET, fill_keys[$urandom_range(0, SLOTS - 1)], rand_word());
  endtask

  // everyday traffic on a small key set, with a little noise
  task automatic mixed_episode();
    int r;
    func_t op;
    // swap out a few pool keys so chains change shape between episodes
    repeat ($urandom_range(0, 4)) key_pool[$urandom_range(0, POOL_N - 1)] = rand_word();
    repeat (40) begin
      r = $urandom_range(0, 99);
      if (r < 42)      op = FUNC_PUT;
      else if (r < 72) op = FUNC_GET;
      else if (r < 95) op = FUNC_REMOVE;
      else if (r < 98) op = FUNC_CLEAR;
      else             op = func_t'($urandom_range(0, 3));
      send_op(op, pick_key(), rand_word());
    end
  endtask

  initial begin : stimulus
    int pick;
    bit filled_once;
    filled_once = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (key_pool[i]) key_pool[i] = rand_word();
    rst_n         <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.func  <= FUNC_PUT;
    in_chan.key   <= '0;
    in_chan.value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, collisions on home slot 0, tombstones, clear
    send_op(FUNC_GET,    64'd0,    ALL_ONES);                 // miss on empty table
    send_op(FUNC_REMOVE, ALL_ONES, 64'd0);                    // remove of absent key
    send_op(FUNC_PUT,    64'd0,    ALL_ONES);
    send_op(FUNC_PUT,    ALL_ONES, 64'd0);                    // home slot 7
    send_op(FUNC_GET,    64'd0,    64'd0);
    send_op(FUNC_GET,    ALL_ONES, ALL_ONES);
    send_op(FUNC_PUT,    64'd0,    64'h5555_5555_5555_5555);  // overwrite
    send_op(FUNC_PUT,    64'd8,    64'hAAAA_AAAA_AAAA_AAAA);  // same home, chains
    send_op(FUNC_PUT,    64'h8000_0000_0000_0000, 64'd1);
    send_op(FUNC_GET,    64'd8,    64'd0);
    send_op(FUNC_REMOVE, 64'd0,    64'd0);                    // leaves a tombstone
    send_op(FUNC_GET,    64'h8000_0000_0000_0000, 64'd0);     // walks past it
    send_op(FUNC_GET,    64'd0,    64'd0);                    // miss past tombstone
    send_op(FUNC_PUT,    64'd16,   64'h0123_4567_89AB_CDEF);  // reuses the tombstone
    send_op(FUNC_GET,    64'd16,   64'd0);
    send_op(FUNC_REMOVE, 64'd8,    64'd0);
    send_op(FUNC_REMOVE, 64'd8,    64'd0);                    // already gone
    send_op(FUNC_PUT,    64'hFFFF_FFFF_FFFF_FFF7, ALL_ONES);  // near miss of all ones
    send_op(FUNC_GET,    64'hFFFF_FFFF_FFFF_FFF7, 64'd0);
    send_op(FUNC_CLEAR,  ALL_ONES, ALL_ONES);
    send_op(FUNC_GET,    64'd16,   64'd0);                    // gone after clear
    send_op(FUNC_PUT,    ALL_ONES, ALL_ONES);
    send_op(FUNC_GET,    ALL_ONES, 64'd0);

    // random episodes, each with its own idling pressure
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 2);
      idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 30;
      if (!filled_once || $urandom_range(0, 7) == 0) begin
        filled_once = 1'b1;
        fill_episode();
      end else begin
        mixed_episode();
      end
    end
    in_chan.valid <= 1'b0;

    // drain, then allow a full-table probe worth of quiet cycles
    do @(posedge clk); while (pending != 0);
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("covered %0d operations: %0d put, %0d get, %0d remove, %0d clear",
             items_sent, op_count[FUNC_PUT], op_count[FUNC_GET], op_count[FUNC_REMOVE],
             op_count[FUNC_CLEAR]);
    $display("%0d replies found the key, %0d puts hit a full table, %0d mismatches",
             hit_count, full_count, fail_count);
    if (fail_count == 0) begin
      $display("linear_probe_hash_table_tb: clean");
    end else begin
      $display("linear_probe_hash_table_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lph_pkg.sv
rtl/lph_if.sv
rtl/lph_ctrl.sv
rtl/lph_dp.sv
rtl/linear_probe_hash_table.sv
dv/linear_probe_hash_table_checker.sv
dv/linear_probe_hash_table_tb.sv
